// ===== hw/rtl/aarl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarl_pkg
// Shared types and constants for the accelerating auto-repeat level block.
// ----------------------------------------------------------------------------
package aarl_pkg;

    localparam int LEVEL_W = 8;
    localparam int STEP_W  = 7;
    localparam int CNT_W   = 16;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 16;

    // register indexes on the configuration port
    localparam logic [IDX_W-1:0] CFG_STEP_SIZE     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_MAX_LEVEL     = 3'd1;
    localparam logic [IDX_W-1:0] CFG_INITIAL_DELAY = 3'd2;
    localparam logic [IDX_W-1:0] CFG_SLOW_PERIOD   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_FAST_PERIOD   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_ACCEL_WINDOW  = 3'd5;

    localparam logic [STEP_W-1:0]  RST_STEP_SIZE     = 7'd5;
    localparam logic [LEVEL_W-1:0] RST_MAX_LEVEL     = 8'd100;
    localparam logic [CNT_W-1:0]   RST_INITIAL_DELAY = 16'd400;
    localparam logic [CNT_W-1:0]   RST_SLOW_PERIOD   = 16'd180;
    localparam logic [CNT_W-1:0]   RST_FAST_PERIOD   = 16'd30;
    localparam logic [CNT_W-1:0]   RST_ACCEL_WINDOW  = 16'd2000;
    localparam logic [LEVEL_W-1:0] RST_LEVEL         = 8'd50;

    typedef struct packed {
        logic [STEP_W-1:0]  step_size;
        logic [LEVEL_W-1:0] max_level;
        logic [CNT_W-1:0]   initial_delay;
        logic [CNT_W-1:0]   slow_period;
        logic [CNT_W-1:0]   fast_period;
        logic [CNT_W-1:0]   accel_window;
    } cfg_t;

    typedef struct packed {
        logic start;   // tick accepted, lane samples its button
        logic ack;     // result taken, lane returns to idle
    } lane_ctl_t;

    typedef struct packed {
        logic done;
        logic press;
        logic rep;
    } lane_stat_t;

    typedef struct packed {
        logic up_press;
        logic dn_press;
        logic up_rep;
        logic dn_rep;
    } step_req_t;

    typedef enum logic [2:0] {
        LANE_IDLE,
        LANE_MUL,
        LANE_DIV,
        LANE_LOAD,
        LANE_DONE
    } lane_state_t;

    typedef enum logic {
        TOP_IDLE,
        TOP_BUSY
    } top_state_t;

endpackage

// ===== hw/rtl/aarl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarl_tick_if / aarl_result_if
// Valid/ready channels for button ticks and level results.
// ----------------------------------------------------------------------------
interface aarl_tick_if;
    logic valid;
    logic ready;
    logic up_level;
    logic down_level;

    modport source (output valid, output up_level, output down_level, input ready);
    modport sink   (input valid, input up_level, input down_level, output ready);
endinterface

interface aarl_result_if;
    logic                         valid;
    logic                         ready;
    logic [aarl_pkg::LEVEL_W-1:0] level;
    logic                         up_stepped;
    logic                         down_stepped;

    modport source (output valid, output level, output up_stepped, output down_stepped,
                    input ready);
    modport sink   (input valid, input level, input up_stepped, input down_stepped,
                    output ready);
endinterface

// ===== hw/rtl/aarl_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarl_lane
// One button: hold counter, repeat countdown and period computation
// (one multiply, then a 16-step restoring divide).
// ----------------------------------------------------------------------------
module aarl_lane (
    input  logic                 clk,
    input  logic                 rst_n,
    input  aarl_pkg::cfg_t       cfg,
    input  logic                 lvl,
    input  aarl_pkg::lane_ctl_t  ctl,
    output aarl_pkg::lane_stat_t stat
);

    localparam int W  = aarl_pkg::CNT_W;
    localparam int CW = $clog2(W);

    aarl_pkg::lane_state_t state_reg, state_next;

    logic [W-1:0]           held_reg, held_next;
    logic [W-1:0]           wait_reg, wait_next;
    logic                   prev_reg;
    logic                   press_reg;
    logic                   due_reg;
    logic                   fast_reg;
    logic [CW-1:0]          cnt_reg, cnt_next;

    logic [W-1:0]           slow_reg;
    logic [W-1:0]           diff_reg;
    logic [W-1:0]           into_reg;
    logic [W-1:0]           rem_reg, rem_next;
    logic [W-1:0]           dvd_reg;
    logic [W-1:0]           quot_reg;

    logic [W-1:0]           held_calc;
    logic [W-1:0]           wait_dec;
    logic [W:0]             limit;
    logic [W-1:0]           slow_eff;
    logic                   due_calc;
    logic                   fast_calc;
    logic [2*W-1:0]         prod;
    logic [W:0]             trial;
    logic [W:0]             rem_sub;
    logic                   qbit;

    always_comb
    begin
        if (!lvl || !prev_reg)
            held_calc = '0;
        else if (held_reg != {W{1'b1}})
            held_calc = held_reg + 1'b1;
        else
            held_calc = held_reg;

        wait_dec  = (wait_reg != '0) ? wait_reg - 1'b1 : '0;
        due_calc  = lvl && (held_calc >= cfg.initial_delay) && (wait_dec == '0);
        limit     = {1'b0, cfg.initial_delay} + {1'b0, cfg.accel_window};
        fast_calc = ({1'b0, held_calc} >= limit) || (cfg.accel_window == '0);
        slow_eff  = (cfg.slow_period < cfg.fast_period) ? cfg.fast_period : cfg.slow_period;

        prod  = diff_reg * into_reg;
        // remainder stays below the divisor, so it always fits W bits
        trial   = {rem_reg, dvd_reg[W-1]};
        qbit    = (trial >= {1'b0, cfg.accel_window});
        rem_sub = trial - {1'b0, cfg.accel_window};
        rem_next = qbit ? rem_sub[W-1:0] : trial[W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        held_next  = held_reg;
        wait_next  = wait_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            aarl_pkg::LANE_IDLE:
            begin
                if (ctl.start)
                begin
                    held_next  = held_calc;
                    wait_next  = wait_dec;
                    state_next = aarl_pkg::LANE_MUL;
                end
            end
            aarl_pkg::LANE_MUL:
            begin
                cnt_next   = '0;
                state_next = aarl_pkg::LANE_DIV;
            end
            aarl_pkg::LANE_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                    state_next = aarl_pkg::LANE_LOAD;
            end
            aarl_pkg::LANE_LOAD:
            begin
                if (due_reg)
                    wait_next = fast_reg ? cfg.fast_period : slow_reg - quot_reg;
                state_next = aarl_pkg::LANE_DONE;
            end
            aarl_pkg::LANE_DONE:
            begin
                if (ctl.ack)
                    state_next = aarl_pkg::LANE_IDLE;
            end
            default:
            begin
                state_next = aarl_pkg::LANE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aarl_pkg::LANE_IDLE;
            held_reg  <= '0;
            wait_reg  <= '0;
            prev_reg  <= 1'b0;
            press_reg <= 1'b0;
            due_reg   <= 1'b0;
            fast_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            wait_reg  <= wait_next;
            cnt_reg   <= cnt_next;
            if (state_reg == aarl_pkg::LANE_IDLE && ctl.start)
            begin
                prev_reg  <= lvl;
                press_reg <= lvl && !prev_reg;
                due_reg   <= due_calc;
                fast_reg  <= fast_calc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == aarl_pkg::LANE_IDLE && ctl.start)
        begin
            slow_reg <= slow_eff;
            diff_reg <= slow_eff - cfg.fast_period;
            into_reg <= held_calc - cfg.initial_delay;
        end
        if (state_reg == aarl_pkg::LANE_MUL)
        begin
            // quotient fits 16 bits, so the upper half seeds the remainder
            rem_reg  <= prod[2*W-1:W];
            dvd_reg  <= prod[W-1:0];
            quot_reg <= '0;
        end
        if (state_reg == aarl_pkg::LANE_DIV)
        begin
            rem_reg  <= rem_next;
            dvd_reg  <= {dvd_reg[W-2:0], 1'b0};
            quot_reg <= {quot_reg[W-2:0], qbit};
        end
    end

    assign stat.done  = (state_reg == aarl_pkg::LANE_DONE);
    assign stat.press = press_reg;
    assign stat.rep   = due_reg;

endmodule

// ===== hw/rtl/aarl_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarl_merge
// Holds the output level and applies the lanes' steps in fixed order:
// up press, down press, up repeat, down repeat, each clamped to 0..max.
// ----------------------------------------------------------------------------
module aarl_merge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  aarl_pkg::cfg_t                cfg,
    input  logic                          commit,
    input  aarl_pkg::step_req_t           req,
    output logic [aarl_pkg::LEVEL_W-1:0]  level_next
);

    localparam int LW = aarl_pkg::LEVEL_W;

    logic [LW-1:0] level_reg;
    logic [LW-1:0] s0, s1, s2;

    function automatic logic [LW-1:0] step_once(
        input logic [LW-1:0]               lv,
        input logic                        up,
        input logic [aarl_pkg::STEP_W-1:0] step,
        input logic [LW-1:0]               maxv
    );
        logic [LW:0] v;
        v = '0;
        if (up)
            v = {1'b0, lv} + {{(LW + 1 - aarl_pkg::STEP_W){1'b0}}, step};
        else if ({1'b0, lv} >= {{(LW + 1 - aarl_pkg::STEP_W){1'b0}}, step})
            v = {1'b0, lv} - {{(LW + 1 - aarl_pkg::STEP_W){1'b0}}, step};
        if (v > {1'b0, maxv})
            v = {1'b0, maxv};
        return v[LW-1:0];
    endfunction

    always_comb
    begin
        s0 = req.up_press ? step_once(level_reg, 1'b1, cfg.step_size, cfg.max_level)
                          : level_reg;
        s1 = req.dn_press ? step_once(s0, 1'b0, cfg.step_size, cfg.max_level) : s0;
        s2 = req.up_rep   ? step_once(s1, 1'b1, cfg.step_size, cfg.max_level) : s1;
        level_next = req.dn_rep ? step_once(s2, 1'b0, cfg.step_size, cfg.max_level) : s2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= aarl_pkg::RST_LEVEL;
        else if (commit)
            level_reg <= level_next;
    end

endmodule

// ===== hw/rtl/accelerating_auto_repeat_level_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accelerating_auto_repeat_level_core
// Key auto-repeat with acceleration: two button lanes in parallel, merged
// into one clamped output level per tick.
// ----------------------------------------------------------------------------
//  port      dir   handshake       content
//  tick      in    valid/ready     up_level, down_level (one ms tick)
//  result    out   valid/ready     level, up_stepped, down_stepped
//  cfg_*     in    write enable    register index, 16-bit data
//
//  After the tick transfer each lane does one multiply, 16 divide steps
//  and one reload; the merge then commits both lanes into the result
//  register. One tick is worked on at a time, so the next tick is taken
//  only once the current one has been merged.
//  The result register lets the next tick start while a result waits; the
//  merge stalls only if the previous result is still not taken.
//  Reset restores register defaults and sets the level to 50.
// ----------------------------------------------------------------------------
module accelerating_auto_repeat_level_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [aarl_pkg::IDX_W-1:0]    cfg_index,
    input  logic [aarl_pkg::DATA_W-1:0]   cfg_data,
    aarl_tick_if.sink                     tick,
    aarl_result_if.source                 result
);

    aarl_pkg::cfg_t       cfg_reg;
    aarl_pkg::top_state_t state_reg, state_next;
    aarl_pkg::lane_ctl_t  ctl;
    aarl_pkg::lane_stat_t up_stat, dn_stat;
    aarl_pkg::step_req_t  req;

    logic                          accept;
    logic                          commit;
    logic [aarl_pkg::LEVEL_W-1:0]  level_next;
    logic                          out_valid_reg;
    logic [aarl_pkg::LEVEL_W-1:0]  level_reg;
    logic                          up_stepped_reg;
    logic                          down_stepped_reg;

    assign tick.ready = (state_reg == aarl_pkg::TOP_IDLE);
    assign accept     = tick.valid && tick.ready;

    always_comb
    begin
        state_next = state_reg;
        commit     = 1'b0;
        case (state_reg)
            aarl_pkg::TOP_IDLE:
            begin
                if (accept)
                    state_next = aarl_pkg::TOP_BUSY;
            end
            aarl_pkg::TOP_BUSY:
            begin
                if (up_stat.done && dn_stat.done && (!out_valid_reg || result.ready))
                begin
                    commit     = 1'b1;
                    state_next = aarl_pkg::TOP_IDLE;
                end
            end
            default:
            begin
                state_next = aarl_pkg::TOP_IDLE;
            end
        endcase
    end

    assign ctl.start = accept;
    assign ctl.ack   = commit;

    assign req.up_press = up_stat.press;
    assign req.dn_press = dn_stat.press;
    assign req.up_rep   = up_stat.rep;
    assign req.dn_rep   = dn_stat.rep;

    aarl_lane u_lane_up (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .lvl   (tick.up_level),
        .ctl   (ctl),
        .stat  (up_stat)
    );

    aarl_lane u_lane_dn (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .lvl   (tick.down_level),
        .ctl   (ctl),
        .stat  (dn_stat)
    );

    aarl_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .commit     (commit),
        .req        (req),
        .level_next (level_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aarl_pkg::TOP_IDLE;
            out_valid_reg <= 1'b0;
            cfg_reg.step_size     <= aarl_pkg::RST_STEP_SIZE;
            cfg_reg.max_level     <= aarl_pkg::RST_MAX_LEVEL;
            cfg_reg.initial_delay <= aarl_pkg::RST_INITIAL_DELAY;
            cfg_reg.slow_period   <= aarl_pkg::RST_SLOW_PERIOD;
            cfg_reg.fast_period   <= aarl_pkg::RST_FAST_PERIOD;
            cfg_reg.accel_window  <= aarl_pkg::RST_ACCEL_WINDOW;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    aarl_pkg::CFG_STEP_SIZE:
                        cfg_reg.step_size <= cfg_data[aarl_pkg::STEP_W-1:0];
                    aarl_pkg::CFG_MAX_LEVEL:
                        cfg_reg.max_level <= cfg_data[aarl_pkg::LEVEL_W-1:0];
                    aarl_pkg::CFG_INITIAL_DELAY:
                        cfg_reg.initial_delay <= cfg_data;
                    aarl_pkg::CFG_SLOW_PERIOD:
                        cfg_reg.slow_period <= cfg_data;
                    aarl_pkg::CFG_FAST_PERIOD:
                        cfg_reg.fast_period <= cfg_data;
                    aarl_pkg::CFG_ACCEL_WINDOW:
                        cfg_reg.accel_window <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            level_reg        <= level_next;
            up_stepped_reg   <= up_stat.press || up_stat.rep;
            down_stepped_reg <= dn_stat.press || dn_stat.rep;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.level        = level_reg;
    assign result.up_stepped   = up_stepped_reg;
    assign result.down_stepped = down_stepped_reg;

endmodule

// ===== sim/tb_accelerating_auto_repeat_level_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accelerating_auto_repeat_level_core
// Self-checking bench for the auto-repeat level block. Button ticks go in on
// the tick channel. A behavioral model of the level, hold counters and repeat
// countdowns predicts each result, and every result transfer is compared
// against the oldest prediction. Directed cases first, then runs of random
// button holds under several register settings, back-pressure and extremes.
// ----------------------------------------------------------------------------
module tb_accelerating_auto_repeat_level_core;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 30;

    localparam int LW  = aarl_pkg::LEVEL_W;
    localparam int SW  = aarl_pkg::STEP_W;
    localparam int CNW = aarl_pkg::CNT_W;
    localparam int XW  = aarl_pkg::IDX_W;
    localparam int DW  = aarl_pkg::DATA_W;

    // indexes past the last register; writes there must change nothing
    localparam logic [XW-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [XW-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [LW-1:0] level;
        logic          up_stepped;
        logic          down_stepped;
    } level_result_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           cfg_we;
    logic [XW-1:0]  cfg_index;
    logic [DW-1:0]  cfg_data;

    aarl_tick_if   tick_ch ();
    aarl_result_if res_ch ();

    accelerating_auto_repeat_level_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .result    (res_ch)
    );

    always #5 clk = ~clk;

    // behavioral copy of the block state; lane 0 is up, lane 1 is down
    aarl_pkg::cfg_t model_regs;
    logic [LW-1:0]  model_level;
    logic [CNW-1:0] held_ticks [2];
    logic [CNW-1:0] countdown [2];
    logic           prev_btn [2];

    level_result_t expected_levels [$];

    int  mismatches      = 0;
    int  ticks_sent      = 0;
    int  results_checked = 0;
    int  up_steps        = 0;
    int  down_steps      = 0;
    int  settings_used   = 0;
    bit  tx_idle_on      = 1'b1;
    bit  rx_idle_on      = 1'b1;
    int  hold_off_len    = 0;

    // ------------------------------------------------------------------
    // level model
    // ------------------------------------------------------------------
    function automatic void reset_model();
        model_regs.step_size     = aarl_pkg::RST_STEP_SIZE;
        model_regs.max_level     = aarl_pkg::RST_MAX_LEVEL;
        model_regs.initial_delay = aarl_pkg::RST_INITIAL_DELAY;
        model_regs.slow_period   = aarl_pkg::RST_SLOW_PERIOD;
        model_regs.fast_period   = aarl_pkg::RST_FAST_PERIOD;
        model_regs.accel_window  = aarl_pkg::RST_ACCEL_WINDOW;
        model_level = aarl_pkg::RST_LEVEL;
        for (int b = 0; b < 2; b++)
        begin
            held_ticks[b] = '0;
            countdown[b]  = '0;
            prev_btn[b]   = 1'b0;
        end
    endfunction

    function automatic logic [CNW-1:0] repeat_period(logic [CNW-1:0] held);
        logic [31:0] fast;
        logic [31:0] slow;
        logic [31:0] into;
        logic [31:0] drop;
        fast = 32'(model_regs.fast_period);
        slow = (model_regs.slow_period < model_regs.fast_period) ?
               fast : 32'(model_regs.slow_period);
        if (model_regs.accel_window == '0 ||
            32'(held) >= 32'(model_regs.initial_delay) + 32'(model_regs.accel_window))
            return fast[CNW-1:0];
        into = 32'(held) - 32'(model_regs.initial_delay);
        drop = ((slow - fast) * into) / 32'(model_regs.accel_window);
        return CNW'(slow - drop);
    endfunction

    function automatic logic [LW-1:0] stepped_level(logic [LW-1:0] lvl, logic up);
        int v;
        v = up ? int'(lvl) + int'(model_regs.step_size) : int'(lvl) - int'(model_regs.step_size);
        if (v < 0)
            v = 0;
        if (v > int'(model_regs.max_level))
            v = int'(model_regs.max_level);
        return LW'(v);
    endfunction

    function automatic level_result_t advance_level(logic up, logic dn);
        logic          btn [2];
        logic          press [2];
        logic          rep [2];
        level_result_t r;
        btn[0] = up;
        btn[1] = dn;
        for (int b = 0; b < 2; b++)
        begin
            press[b] = btn[b] && !prev_btn[b];
            if (!btn[b] || !prev_btn[b])
                held_ticks[b] = '0;
            else if (held_ticks[b] != '1)
                held_ticks[b] = held_ticks[b] + 1'b1;
        end
        for (int b = 0; b < 2; b++)
        begin
            if (press[b])
                model_level = stepped_level(model_level, b == 0);
        end
        // countdowns run down even while released (stale countdown)
        for (int b = 0; b < 2; b++)
        begin
            if (countdown[b] != '0)
                countdown[b] = countdown[b] - 1'b1;
            rep[b] = btn[b] && held_ticks[b] >= model_regs.initial_delay && countdown[b] == '0;
            if (rep[b])
            begin
                countdown[b] = repeat_period(held_ticks[b]);
                model_level  = stepped_level(model_level, b == 0);
            end
            prev_btn[b] = btn[b];
        end
        r.level        = model_level;
        r.up_stepped   = press[0] || rep[0];
        r.down_stepped = press[1] || rep[1];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] MISMATCH %s: got %0d, expected %0d (result #%0d)",
                     $realtime, what, got, want, results_checked);
    endtask

    always @(posedge clk)
    begin : result_check
        level_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_levels.size() == 0)
                report_mismatch("result with no tick outstanding", res_ch.level, -1);
            else
            begin
                want = expected_levels.pop_front();
                if (res_ch.level !== want.level)
                    report_mismatch("level", res_ch.level, want.level);
                if (res_ch.up_stepped !== want.up_stepped)
                    report_mismatch("up_stepped", res_ch.up_stepped, want.up_stepped);
                if (res_ch.down_stepped !== want.down_stepped)
                    report_mismatch("down_stepped", res_ch.down_stepped, want.down_stepped);
            end
            results_checked++;
            up_steps   += int'(res_ch.up_stepped === 1'b1);
            down_steps += int'(res_ch.down_stepped === 1'b1);
        end
    end

    // result side: random stall bursts, plus long hold-offs on request
    initial
    begin : result_ready_drive
        int burst;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_len != 0)
            begin
                burst = hold_off_len;
                res_ch.ready <= 1'b0;
                repeat (burst) @(posedge clk);
                hold_off_len = 0;
                res_ch.ready <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 14);
                res_ch.ready <= 1'b0;
                repeat (burst) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_tick(input logic up, input logic dn);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.up_level   <= up;
        tick_ch.down_level <= dn;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        expected_levels.push_back(advance_level(up, dn));
        ticks_sent++;
    endtask

    // stop offering ticks and wait for every outstanding result
    task automatic settle();
        tick_ch.valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic put_reg(input logic [XW-1:0] idx, input logic [DW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            aarl_pkg::CFG_STEP_SIZE:     model_regs.step_size     = data[SW-1:0];
            aarl_pkg::CFG_MAX_LEVEL:     model_regs.max_level     = data[LW-1:0];
            aarl_pkg::CFG_INITIAL_DELAY: model_regs.initial_delay = data[CNW-1:0];
            aarl_pkg::CFG_SLOW_PERIOD:   model_regs.slow_period   = data[CNW-1:0];
            aarl_pkg::CFG_FAST_PERIOD:   model_regs.fast_period   = data[CNW-1:0];
            aarl_pkg::CFG_ACCEL_WINDOW:  model_regs.accel_window  = data[CNW-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_config(input aarl_pkg::cfg_t c);
        settle();
        put_reg(aarl_pkg::CFG_STEP_SIZE,     DW'(c.step_size));
        put_reg(aarl_pkg::CFG_MAX_LEVEL,     DW'(c.max_level));
        put_reg(aarl_pkg::CFG_INITIAL_DELAY, DW'(c.initial_delay));
        put_reg(aarl_pkg::CFG_SLOW_PERIOD,   DW'(c.slow_period));
        put_reg(aarl_pkg::CFG_FAST_PERIOD,   DW'(c.fast_period));
        put_reg(aarl_pkg::CFG_ACCEL_WINDOW,  DW'(c.accel_window));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // button runs: mostly clean press/hold/release, noise_pct of ticks random
    task automatic drive_holds(input int n_items, input int long_hold, input int noise_pct);
        logic [1:0] btn;
        int         run_left [2];
        btn = 2'b00;
        run_left[0] = 0;
        run_left[1] = 0;
        for (int i = 0; i < n_items; i++)
        begin
            for (int b = 0; b < 2; b++)
            begin
                if (run_left[b] == 0)
                begin
                    btn[b] = !btn[b];
                    if (!btn[b])
                        run_left[b] = $urandom_range(1, 6);
                    else if ($urandom_range(0, 9) < 7)
                        run_left[b] = $urandom_range(1, 12);
                    else
                        run_left[b] = $urandom_range(1, long_hold);
                end
                run_left[b]--;
            end
            if ($urandom_range(0, 99) < noise_pct)
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
                send_tick(btn[0], btn[1]);
        end
    endtask

    function automatic aarl_pkg::cfg_t pick_short_config();
        aarl_pkg::cfg_t c;
        c.step_size = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                                  : 7'($urandom_range(1, 12));
        case ($urandom_range(0, 5))
            0:       c.max_level = 8'd255;
            1:       c.max_level = 8'($urandom_range(1, 20));
            default: c.max_level = 8'($urandom_range(30, 255));
        endcase
        c.initial_delay = 16'($urandom_range(0, 12));
        c.slow_period   = 16'($urandom_range(1, 40));
        c.fast_period   = 16'($urandom_range(1, 20));
        c.accel_window  = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 60));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
    endtask

    // zero delay and zero period: press and repeat on the same tick, then
    // a repeat on every tick while held
    task automatic test_zero_period();
        aarl_pkg::cfg_t c;
        c.step_size     = 7'd127;
        c.max_level     = 8'd255;
        c.initial_delay = 16'd0;
        c.slow_period   = 16'd0;
        c.fast_period   = 16'd0;
        c.accel_window  = 16'd0;
        apply_config(c);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
    endtask

    task automatic test_zero_max_and_step();
        aarl_pkg::cfg_t c;
        c = model_regs;
        c.max_level = 8'd0;
        c.step_size = 7'd5;
        apply_config(c);
        send_tick(1'b1, 1'b0);
        c.max_level = 8'd255;
        c.step_size = 7'd0;
        apply_config(c);
        send_tick(1'b0, 1'b1);
    endtask

    // lowering max_level below the level: the next down step still clamps
    task automatic test_level_above_max();
        aarl_pkg::cfg_t c;
        c = model_regs;
        c.step_size     = 7'd127;
        c.max_level     = 8'd255;
        c.initial_delay = 16'hFFFF;
        apply_config(c);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        c.max_level = 8'd10;
        apply_config(c);
        send_tick(1'b0, 1'b1);
    endtask

    task automatic test_stale_countdown();
        aarl_pkg::cfg_t c;
        c.step_size     = 7'd1;
        c.max_level     = 8'd255;
        c.initial_delay = 16'd3;
        c.slow_period   = 16'd4;
        c.fast_period   = 16'd4;
        c.accel_window  = 16'd1;
        apply_config(c);
        repeat (5) send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        repeat (3) send_tick(1'b1, 1'b0);
    endtask

    task automatic test_spare_indexes();
        settle();
        put_reg(CFG_SPARE_LO, 16'hFFFF);
        put_reg(CFG_SPARE_HI, 16'h0000);
        cfg_we <= 1'b0;
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
    endtask

    task automatic test_random_short();
        aarl_pkg::cfg_t c;
        int             long_hold;
        for (int p = 0; p < 8; p++)
        begin
            c = pick_short_config();
            apply_config(c);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            long_hold = int'(c.initial_delay) + 4 * int'(c.slow_period) + int'(c.accel_window);
            drive_holds(100, (long_hold > 200) ? 200 : long_hold + 1, 10);
        end
    endtask

    // result side held off long enough that the block backs up into the
    // tick channel; then the sender waits for everything to drain
    task automatic test_result_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        hold_off_len = $urandom_range(200, 400);
        drive_holds(24, 20, 10);
        settle();
    endtask

    // long ramps with wide products in the period calculation
    task automatic test_random_wide();
        aarl_pkg::cfg_t c;
        for (int p = 0; p < 3; p++)
        begin
            c.step_size     = 7'($urandom_range(1, 20));
            c.max_level     = ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom_range(1, 255));
            c.initial_delay = 16'($urandom_range(0, 10));
            c.slow_period   = 16'($urandom_range(40, 250));
            c.fast_period   = 16'($urandom_range(1, 20));
            c.accel_window  = 16'($urandom_range(100, 2000));
            apply_config(c);
            tx_idle_on = 1'b1;
            rx_idle_on = (p != 1);
            drive_holds(150, 400, 5);
        end
    endtask

    // register extremes; a full-length period leaves the countdowns loaded,
    // so this runs last
    task automatic test_extreme_registers();
        aarl_pkg::cfg_t c;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        c.step_size     = 7'd127;
        c.max_level     = 8'd255;
        c.initial_delay = 16'hFFFF;
        c.slow_period   = 16'hFFFF;
        c.fast_period   = 16'hFFFF;
        c.accel_window  = 16'hFFFF;
        apply_config(c);
        drive_holds(100, 60, 5);
        c.step_size     = 7'd1;
        c.max_level     = 8'd1;
        c.initial_delay = 16'd0;
        c.fast_period   = 16'd1;
        apply_config(c);
        drive_holds(100, 60, 5);
    endtask

    initial
    begin : main_seq
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        tick_ch.valid      <= 1'b0;
        tick_ch.up_level   <= 1'b0;
        tick_ch.down_level <= 1'b0;
        reset_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_period();
        test_zero_max_and_step();
        test_level_above_max();
        test_stale_countdown();
        test_spare_indexes();
        test_random_short();
        test_result_backpressure();
        test_random_wide();
        test_extreme_registers();

        settle();
        repeat (40) @(posedge clk);
        $display("Covered %0d ticks under %0d register settings, %0d results checked",
                 ticks_sent, settings_used, results_checked);
        $display("Steps seen: %0d up, %0d down; %0d mismatches",
                 up_steps, down_steps, mismatches);
        if (mismatches == 0 && expected_levels.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
